>>> src/bfth_pkg.sv
// ----------------------------------------------------------------------------
// Bloom filter package
// Hash constants, the action codes and the controller/datapath command and
// status types.
// ----------------------------------------------------------------------------
package bfth_pkg;

  localparam int unsigned FilterBitsDefault = 65536;

  localparam logic [31:0] FnvOffset = 32'h811C9DC5;
  localparam logic [31:0] FnvPrime  = 32'h01000193;
  localparam logic [31:0] HashSeed  = 32'd42;

  localparam logic [31:0] MmC1 = 32'hCC9E2D51;
  localparam logic [31:0] MmC2 = 32'h1B873593;
  localparam logic [31:0] MmN  = 32'hE6546B64;
  localparam logic [31:0] MmF1 = 32'h85EBCA6B;
  localparam logic [31:0] MmF2 = 32'hC2B2AE35;

  localparam logic [31:0] XxP2 = 32'h85EBCA77;
  localparam logic [31:0] XxP3 = 32'hC2B2AE3D;
  localparam logic [31:0] XxP4 = 32'h27D4EB2F;
  localparam logic [31:0] XxP5 = 32'h165667B1;

  // Number of hash rounds; each round registers the hash values once.
  localparam int unsigned HashSteps = 5;

  typedef enum logic {
    ActInsert = 1'b0,
    ActQuery  = 1'b1
  } action_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture a new key and action
    logic       step;      // advance the hash rounds by one
    logic       clr;       // clear one store word
    logic       probe;     // access the store at the selected hash
    logic [1:0] probe_sel; // which hash result to use
    logic       acc_init;  // restart the query accumulator
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    logic is_query;
  } stat_t;

endpackage

>>> src/bloom_filter_three_hash.sv
// ----------------------------------------------------------------------------
// Bloom filter with three hashes
// Top level: controller and datapath.
// ----------------------------------------------------------------------------
// An item is a key with an insert or query action. Once accepted, an item
// takes five hash rounds (at most one 32-bit multiply per hash per round) and
// three probes of the bit store, one a cycle; an insert sets its bits by
// reading a word and writing it back in the next cycle, overlapped with the
// next probe. in_stall_o falls once the third probe of an insert is done, so
// no new item is taken before then. A query adds a read drain state and a
// result state: its answer is registered in the result state, which waits
// while an earlier answer is held by out_stall_i, and the next item can be
// taken once it is registered. After reset the store is cleared one 32-bit
// word a cycle, with in_stall_o held high.
module bloom_filter_three_hash
  import bfth_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FilterBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [31:0] key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        maybe_present_o
);

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] round;
  logic       hit;

  bfth_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .stat_i     (stat),
    .hit_i      (hit),
    .cmd_o      (cmd),
    .round_o    (round),
    .result_o   (maybe_present_o)
  );

  bfth_datapath #(.FILTER_BITS(FILTER_BITS)) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .round_i (round),
    .action_i(action_i),
    .key_i   (key_i),
    .stat_o  (stat),
    .hit_o   (hit)
  );

endmodule

>>> src/bfth_hash.sv
// ----------------------------------------------------------------------------
// Bloom filter hash unit
// Computes FNV-1a, MurmurHash3 and XXH32 of one key over five registered
// rounds, at most one multiply per hash per round.
// ----------------------------------------------------------------------------
module bfth_hash
  import bfth_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  logic        step_i,
  input  logic [31:0] key_i,
  input  logic [2:0]  round_i,
  output logic [31:0] fnv_o,
  output logic [31:0] mm_o,
  output logic [31:0] xx_o
);

  logic [31:0] key_q;
  logic [31:0] fnv_q, fnv_d;
  logic [31:0] mm_q, mm_d;
  logic [31:0] xx_q, xx_d;
  logic [31:0] mm_t, xx_t;

  // One round of each hash, chosen by the round number.
  always_comb begin
    fnv_d = fnv_q;
    mm_d  = mm_q;
    xx_d  = xx_q;
    mm_t  = '0;
    xx_t  = '0;
    case (round_i)
      3'd0: begin
        fnv_d = (FnvOffset ^ {24'd0, key_q[7:0]}) * FnvPrime;
        mm_d  = key_q * MmC1;
        xx_d  = key_q * XxP3;
      end
      3'd1: begin
        fnv_d = (fnv_q ^ {24'd0, key_q[15:8]}) * FnvPrime;
        mm_d  = {mm_q[16:0], mm_q[31:17]} * MmC2;
        xx_t  = xx_q + HashSeed + XxP5 + 32'd4;
        xx_d  = {xx_t[14:0], xx_t[31:15]} * XxP4;
      end
      3'd2: begin
        fnv_d = (fnv_q ^ {24'd0, key_q[23:16]}) * FnvPrime;
        mm_t  = HashSeed ^ mm_q;
        mm_t  = ({mm_t[18:0], mm_t[31:19]} * 32'd5 + MmN) ^ 32'd4;
        mm_d  = (mm_t ^ (mm_t >> 16)) * MmF1;
        xx_d  = (xx_q ^ (xx_q >> 15)) * XxP2;
      end
      3'd3: begin
        fnv_d = (fnv_q ^ {24'd0, key_q[31:24]}) * FnvPrime;
        mm_d  = (mm_q ^ (mm_q >> 13)) * MmF2;
        xx_d  = (xx_q ^ (xx_q >> 13)) * XxP3;
      end
      3'd4: begin
        mm_d = mm_q ^ (mm_q >> 16);
        xx_d = xx_q ^ (xx_q >> 16);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= key_i;
    end
    if (step_i) begin
      fnv_q <= fnv_d;
      mm_q  <= mm_d;
      xx_q  <= xx_d;
    end
  end

  assign fnv_o = fnv_q;
  assign mm_o  = mm_q;
  assign xx_o  = xx_q;

endmodule

>>> src/bfth_datapath.sv
// ----------------------------------------------------------------------------
// Bloom filter datapath
// Holds the key, the hash unit, the bit store and the query accumulator.
// ----------------------------------------------------------------------------
module bfth_datapath
  import bfth_pkg::*;
#(
  parameter int unsigned FILTER_BITS = FilterBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [2:0]  round_i,
  input  logic        action_i,
  input  logic [31:0] key_i,
  output stat_t       stat_o,
  output logic        hit_o
);

  localparam int unsigned AddrW  = $clog2(FILTER_BITS);
  localparam int unsigned WordW  = 32;
  localparam int unsigned Words  = FILTER_BITS / WordW;
  localparam int unsigned WAddrW = AddrW - 5;

  logic [WordW-1:0]  mem_q [Words];
  logic [WordW-1:0]  rd_q;
  logic [31:0]       fnv, mm, xx;
  logic [31:0]       hsel;
  logic [AddrW-1:0]  pos;
  logic [WAddrW-1:0] rd_addr;
  logic [WAddrW-1:0] wr_addr_q;
  logic [WordW-1:0]  wr_data;
  logic              wr_en_q;
  logic [4:0]        bit_q;
  logic              rd_en_q;
  logic              action_q;
  logic              acc_q;
  logic [WAddrW-1:0] clr_q;

  bfth_hash u_hash (
    .clk_i  (clk_i),
    .load_i (cmd_i.load),
    .step_i (cmd_i.step),
    .key_i  (key_i),
    .round_i(round_i),
    .fnv_o  (fnv),
    .mm_o   (mm),
    .xx_o   (xx)
  );

  // Select the hash for this probe and keep its low bits.
  always_comb begin
    case (cmd_i.probe_sel)
      2'd0:    hsel = fnv;
      2'd1:    hsel = mm;
      default: hsel = xx;
    endcase
  end
  assign pos     = hsel[AddrW-1:0];
  assign rd_addr = pos[AddrW-1:5];

  // The word read for an insert probe comes back with its bit set.
  assign wr_data = rd_q | (WordW'(1) << bit_q);

  // Store access: clearing sweep, or the write-back of an insert probe in the
  // cycle after its read. A read of the word being written takes the new data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[clr_q] <= '0;
    end else if (wr_en_q) begin
      mem_q[wr_addr_q] <= wr_data;
    end
    if (wr_en_q && wr_addr_q == rd_addr) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[rd_addr];
    end
    wr_addr_q <= rd_addr;
    bit_q     <= pos[4:0];
  end

  // Control registers: action, clear counter, query accumulator.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q <= ActInsert;
      clr_q    <= '0;
      acc_q    <= 1'b1;
      rd_en_q  <= 1'b0;
      wr_en_q  <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        action_q <= action_i;
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + WAddrW'(1);
      end
      rd_en_q <= cmd_i.probe && action_q == ActQuery;
      wr_en_q <= cmd_i.probe && action_q == ActInsert;
      if (cmd_i.acc_init) begin
        acc_q <= 1'b1;
      end else if (rd_en_q) begin
        acc_q <= acc_q & rd_q[bit_q];
      end
    end
  end

  assign hit_o           = acc_q;
  assign stat_o.clr_last = (clr_q == WAddrW'(Words - 1));
  assign stat_o.is_query = (action_q == ActQuery);

endmodule

>>> src/bfth_ctrl.sv
// ----------------------------------------------------------------------------
// Bloom filter controller
// Sequences the clearing sweep, the hash rounds, the three probes and the
// result register.
// ----------------------------------------------------------------------------
module bfth_ctrl
  import bfth_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  stat_t      stat_i,
  input  logic       hit_i,
  output cmd_t       cmd_o,
  output logic [2:0] round_o,
  output logic       result_o
);

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StHash,
    StProbe,
    StDrain,
    StResult
  } state_e;

  state_e      state_q;
  logic [2:0]  round_q;
  logic [1:0]  probe_q;
  logic        out_valid_q;
  logic        result_q;
  logic        out_free;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle);

  // Commands decoded from the current state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.clr       = (state_q == StClear);
    cmd_o.load      = (state_q == StIdle) && in_valid_i;
    cmd_o.acc_init  = cmd_o.load;
    cmd_o.step      = (state_q == StHash);
    cmd_o.probe     = (state_q == StProbe);
    cmd_o.probe_sel = probe_q;
  end
  assign round_o = round_q;

  // State, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      round_q     <= '0;
      probe_q     <= '0;
      out_valid_q <= 1'b0;
      result_q    <= 1'b0;
    end else begin
      if (state_q == StResult && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          if (stat_i.clr_last) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_valid_i) begin
            round_q <= '0;
            state_q <= StHash;
          end
        end
        StHash: begin
          round_q <= round_q + 3'd1;
          if (round_q == 3'(HashSteps - 1)) begin
            probe_q <= '0;
            state_q <= StProbe;
          end
        end
        StProbe: begin
          probe_q <= probe_q + 2'd1;
          if (probe_q == 2'd2) begin
            state_q <= stat_i.is_query ? StDrain : StIdle;
          end
        end
        StDrain: begin
          state_q <= StResult;
        end
        StResult: begin
          if (out_free) begin
            result_q <= hit_i;
            state_q  <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

>>> src/bfth_checker.sv
// ----------------------------------------------------------------------------
// Bloom filter port checker
// Watches the top level's ports over time.
// ----------------------------------------------------------------------------
module bfth_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic maybe_present_o
);

  // An accepted item blocks the next one in the following cycle.
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("back-to-back accept");

  // No result appears right after an accept.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o)) else $error("early result");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(maybe_present_o))
    else $error("result dropped");

endmodule

bind bloom_filter_three_hash bfth_checker u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .maybe_present_o(maybe_present_o)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Drives insert and query items into the three-hash Bloom filter and checks
// every query answer against a behavioural copy of the filter kept here.
// ----------------------------------------------------------------------------
module tb_top
  import bfth_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FilterBits = FilterBitsDefault;
  localparam int unsigned StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [31:0] key_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        maybe_present_o;

  bloom_filter_three_hash #(.FILTER_BITS(FilterBits)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .key_i          (key_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .maybe_present_o(maybe_present_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow copy of the bit store and the queue of expected answers.
  bit          shadow_bits [FilterBits];
  bit          answer_q [$];
  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;
  bit [31:0]   key_hist [$];

  function automatic bit [31:0] rotl(bit [31:0] v, int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function automatic bit [31:0] fnv_hash(bit [31:0] k);
    bit [31:0] h;
    h = FnvOffset;
    for (int i = 0; i < 4; i++) begin
      h = (h ^ ((k >> (8 * i)) & 32'hFF)) * FnvPrime;
    end
    return h;
  endfunction

  function automatic bit [31:0] murmur_hash(bit [31:0] k);
    bit [31:0] m;
    bit [31:0] h;
    m = rotl(k * MmC1, 15) * MmC2;
    h = rotl(HashSeed ^ m, 13) * 32'd5 + MmN;
    h = h ^ 32'd4;
    h = (h ^ (h >> 16)) * MmF1;
    h = (h ^ (h >> 13)) * MmF2;
    return h ^ (h >> 16);
  endfunction

  function automatic bit [31:0] xx_hash(bit [31:0] k);
    bit [31:0] h;
    h = HashSeed + XxP5 + 32'd4 + k * XxP3;
    h = rotl(h, 17) * XxP4;
    h = (h ^ (h >> 15)) * XxP2;
    h = (h ^ (h >> 13)) * XxP3;
    return h ^ (h >> 16);
  endfunction

  // Applies one accepted item to the shadow store and queues any answer.
  task automatic filter_predict(action_e act, bit [31:0] k);
    int unsigned p1;
    int unsigned p2;
    int unsigned p3;
    p1 = fnv_hash(k) % FilterBits;
    p2 = murmur_hash(k) % FilterBits;
    p3 = xx_hash(k) % FilterBits;
    if (act == ActInsert) begin
      shadow_bits[p1] = 1'b1;
      shadow_bits[p2] = 1'b1;
      shadow_bits[p3] = 1'b1;
    end else begin
      answer_q.push_back(shadow_bits[p1] & shadow_bits[p2] & shadow_bits[p3]);
    end
  endtask

  // Offers one item and waits for its acceptance.
  task automatic send_item(action_e act, bit [31:0] k);
    in_valid_i <= 1'b1;
    action_i   <= act;
    key_i      <= k;
    do @(posedge clk_i); while (in_stall_o);
    filter_predict(act, k);
    if (act == ActInsert) key_hist.push_back(k);
  endtask

  task automatic drop_valid();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Directed rows; fixed answers only where known: empty store or key inserted.
  typedef struct {
    action_e   act;
    bit [31:0] k;
    bit        fixed;
    bit        answer;
  } row_t;

  row_t dir_rows [] = '{
    '{ActQuery,  32'h0000_0000, 1'b1, 1'b0},
    '{ActQuery,  32'hFFFF_FFFF, 1'b1, 1'b0},
    '{ActQuery,  32'h1234_5678, 1'b1, 1'b0},
    '{ActInsert, 32'h0000_0000, 1'b0, 1'b0},
    '{ActQuery,  32'h0000_0000, 1'b1, 1'b1},
    '{ActInsert, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{ActQuery,  32'hFFFF_FFFF, 1'b1, 1'b1},
    '{ActInsert, 32'hFFFF_FFFF, 1'b0, 1'b0},
    '{ActQuery,  32'hFFFF_FFFF, 1'b1, 1'b1},
    '{ActInsert, 32'h8000_0000, 1'b0, 1'b0},
    '{ActInsert, 32'h0000_0001, 1'b0, 1'b0},
    '{ActInsert, 32'hAAAA_AAAA, 1'b0, 1'b0},
    '{ActInsert, 32'h5555_5555, 1'b0, 1'b0},
    '{ActQuery,  32'h8000_0000, 1'b1, 1'b1},
    '{ActQuery,  32'h0000_0001, 1'b1, 1'b1},
    '{ActQuery,  32'hAAAA_AAAA, 1'b1, 1'b1},
    '{ActQuery,  32'h5555_5555, 1'b1, 1'b1},
    '{ActQuery,  32'h0000_0002, 1'b0, 1'b0},
    '{ActQuery,  32'hDEAD_BEEF, 1'b0, 1'b0}
  };

  // Stimulus: directed table, then bursts of random items.
  initial begin
    action_e   act;
    bit [31:0] k;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].fixed) begin
        bit got;
        got = shadow_bits[fnv_hash(dir_rows[i].k) % FilterBits]
            & shadow_bits[murmur_hash(dir_rows[i].k) % FilterBits]
            & shadow_bits[xx_hash(dir_rows[i].k) % FilterBits];
        if (got != dir_rows[i].answer) begin
          $display("%0t: row %0d table answer %0b, predicted %0b",
                   $time, i, dir_rows[i].answer, got);
          fail_cnt++;
        end
      end
      send_item(dir_rows[i].act, dir_rows[i].k);
    end
    drop_valid();
    // Sender holds off until every answer has come back.
    wait (answer_q.size() == 0);
    for (int n = 0; n < 530;) begin
      int unsigned burst;
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        // Mix of fresh keys, re-used inserted keys, near neighbours and small keys.
        act = action_e'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: k = $urandom();
          1: k = key_hist.size() ? key_hist[$urandom_range(0, key_hist.size() - 1)]
                                 : $urandom();
          2: k = key_hist.size() ? key_hist[$urandom_range(0, key_hist.size() - 1)]
                                   ^ (32'h1 << $urandom_range(0, 31))
                                 : $urandom();
          default: k = $urandom_range(0, 255);
        endcase
        if (n == 100) long_hold <= 1'b1;
        send_item(act, k);
      end
      if ($urandom_range(0, 2) != 0) begin
        drop_valid();
        repeat ($urandom_range(0, 15)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern, with one long hold-off mid-run.
  initial begin
    int unsigned phase;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
        long_hold = 1'b0;
      end
      phase = $urandom_range(0, 9);
      if (phase < 3) out_stall_i <= 1'b0;
      else if (phase < 8) out_stall_i <= $urandom_range(0, 1);
      else out_stall_i <= 1'b1;
    end
  end

  // Answer checking.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected answer %0b", $time, maybe_present_o);
        fail_cnt++;
      end else begin
        bit exp_ans;
        exp_ans = answer_q.pop_front();
        if (maybe_present_o !== exp_ans) begin
          $display("%0t: maybe_present expected %0b actual %0b",
                   $time, exp_ans, maybe_present_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted item or taken answer; the reset clear is covered.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit + FilterBits / 32) begin
      $display("bloom_filter_three_hash verification failed");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (answer_q.size() == 0);
    repeat (40) @(posedge clk_i);
    if (fail_cnt == 0 && answer_q.size() == 0) begin
      $display("bloom_filter_three_hash verification clean");
    end else begin
      $display("bloom_filter_three_hash verification failed");
    end
    $finish;
  end

endmodule
